// ----- hw/rtl/lss_pkg.sv -----
// ---------------------------------------------------------------------------
// lss_pkg: shared types, constants and helpers for the line search block
// Field widths, request kinds, register indexes and the character
// classification and folding helpers.
// ---------------------------------------------------------------------------
package lss_pkg;

   localparam int LINE_MAX_DEF = 64;
   localparam int TERM_MAX_DEF = 16;
   localparam int MAX_RESULTS  = 64;

   localparam int CP_W       = 21;
   localparam int LINE_NUM_W = 16;
   localparam int COL_W      = 6;
   localparam int LEN_W      = 5;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 8;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;

   localparam logic [CSR_IDX_W-1:0] REG_WHOLE_WORD = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FOLD_CASE  = 4'd1;

   localparam logic [1:0] KIND_TERM      = 2'd0;
   localparam logic [1:0] KIND_TERM_LAST = 2'd1;
   localparam logic [1:0] KIND_LINE      = 2'd2;
   localparam logic [1:0] KIND_LINE_LAST = 2'd3;

   localparam logic [CP_W-1:0] CP_DIGIT_0    = 21'h30;
   localparam logic [CP_W-1:0] CP_DIGIT_9    = 21'h39;
   localparam logic [CP_W-1:0] CP_UPPER_A    = 21'h41;
   localparam logic [CP_W-1:0] CP_UPPER_Z    = 21'h5A;
   localparam logic [CP_W-1:0] CP_LOWER_A    = 21'h61;
   localparam logic [CP_W-1:0] CP_LOWER_Z    = 21'h7A;
   localparam logic [CP_W-1:0] CP_UNDERSCORE = 21'h5F;
   localparam logic [CP_W-1:0] CP_CASE_DELTA = 21'h20;

   typedef struct packed {
      logic [1:0]            kind;
      logic [CP_W-1:0]       cp;
      logic                  word;
      logic [LINE_NUM_W-1:0] line_number;
   } lss_entry_type;

   typedef struct packed {
      logic whole_word;
      logic fold_case;
   } lss_cfg_type;

   function automatic logic is_word_char(input logic [CP_W-1:0] c);
      return (c inside {[CP_DIGIT_0:CP_DIGIT_9]}) || (c inside {[CP_UPPER_A:CP_UPPER_Z]}) ||
             (c inside {[CP_LOWER_A:CP_LOWER_Z]}) || (c == CP_UNDERSCORE);
   endfunction

   function automatic logic [CP_W-1:0] fold_cp(input logic [CP_W-1:0] c, input logic ci);
      if (ci && (c inside {[CP_UPPER_A:CP_UPPER_Z]})) begin
         return c + CP_CASE_DELTA;
      end
      return c;
   endfunction

endpackage

// ----- hw/rtl/lss_req_if.sv -----
// ---------------------------------------------------------------------------
// lss_req_if: request channel
// Valid/ready channel carrying one term or line character.
// ---------------------------------------------------------------------------
interface lss_req_if;
   import lss_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  cmd;
   logic [CP_W-1:0]       code_point;
   logic                  last;
   logic [LINE_NUM_W-1:0] line_number;

   modport source (output valid, cmd, code_point, last, line_number, input ready);
   modport sink   (input valid, cmd, code_point, last, line_number, output ready);
endinterface

// ----- hw/rtl/lss_rsp_if.sv -----
// ---------------------------------------------------------------------------
// lss_rsp_if: result channel
// Valid/ready channel carrying one match or not-found result.
// ---------------------------------------------------------------------------
interface lss_rsp_if;
   import lss_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  found;
   logic [LINE_NUM_W-1:0] match_line;
   logic [COL_W-1:0]      column;
   logic [LEN_W-1:0]      match_length;
   logic                  end_of_results;
   logic                  overflow;

   modport source (output valid, found, match_line, column, match_length, end_of_results,
                   overflow, input ready);
   modport sink   (input valid, found, match_line, column, match_length, end_of_results,
                   overflow, output ready);
endinterface

// ----- hw/rtl/lss_csr_if.sv -----
// ---------------------------------------------------------------------------
// lss_csr_if: register write channel
// Valid/ready channel carrying a register index and write data.
// ---------------------------------------------------------------------------
interface lss_csr_if;
   import lss_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

// ----- hw/rtl/line_substring_search.sv -----
// Flow: a term or line character passes the queue into its store; requests are taken
// one per cycle while the two-entry queue has room; it drains one per cycle only in idle.
// Line end: candidate starts are tried in turn, each compared character taking a
// registered line memory read; in whole-word mode each occurrence gets neighbor checks.
// Each result leaves through one output register.
// Reset: synchronous; clears control, registers and counts, no clearing pass on the stores.
// ---------------------------------------------------------------------------
// line_substring_search: substring search over a line of code points
// Term and line characters are queued, stored, and the line is searched at
// its last character; one result per match (up to MAX_RESULTS) or one not-found result.
// ---------------------------------------------------------------------------
module line_substring_search #(
   parameter int LINE_MAX = lss_pkg::LINE_MAX_DEF,
   parameter int TERM_MAX = lss_pkg::TERM_MAX_DEF
) (
   input  logic       clock,
   input  logic       reset,
   lss_req_if.sink    req_ch,
   lss_rsp_if.source  rsp_ch,
   lss_csr_if.sink    csr_ch
);
   import lss_pkg::*;

   logic          whole_word_ff, fold_case_ff;
   lss_cfg_type   cfg;
   logic          push_valid, push_ready, pop_valid, pop_ready;
   lss_entry_type push_data, pop_data;

   assign csr_ch.ready   = 1'b1;
   assign cfg.whole_word = whole_word_ff;
   assign cfg.fold_case  = fold_case_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         whole_word_ff <= 1'b0;
         fold_case_ff  <= 1'b0;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            REG_WHOLE_WORD: whole_word_ff <= csr_ch.wdata[0];
            REG_FOLD_CASE:  fold_case_ff  <= csr_ch.wdata[0];
            default: ;
         endcase
      end
   end

   lss_front u_front (
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   lss_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   lss_back #(
      .LINE_MAX (LINE_MAX),
      .TERM_MAX (TERM_MAX)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_ch    (rsp_ch)
   );

endmodule

// ----- hw/rtl/lss_front.sv -----
// ---------------------------------------------------------------------------
// lss_front: request intake
// Accepts requests, tags each with its kind and word-character class and
// pushes it into the queue.
// ---------------------------------------------------------------------------
module lss_front (
   lss_req_if.sink              req_ch,
   output logic                 push_valid,
   input  logic                 push_ready,
   output lss_pkg::lss_entry_type push_data
);
   import lss_pkg::*;

   logic [1:0] kind;

   always_comb begin
      case ({req_ch.cmd, req_ch.last})
         2'b00:   kind = KIND_TERM;
         2'b01:   kind = KIND_TERM_LAST;
         2'b10:   kind = KIND_LINE;
         default: kind = KIND_LINE_LAST;
      endcase
   end

   assign push_valid            = req_ch.valid;
   assign req_ch.ready          = push_ready;
   assign push_data.kind        = kind;
   assign push_data.cp          = req_ch.code_point;
   assign push_data.word        = is_word_char(req_ch.code_point);
   assign push_data.line_number = req_ch.line_number;

endmodule

// ----- hw/rtl/lss_queue.sv -----
// ---------------------------------------------------------------------------
// lss_queue: request queue
// Short FIFO between intake and search so each side stalls on its own.
// ---------------------------------------------------------------------------
module lss_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   output logic                   push_ready,
   input  lss_pkg::lss_entry_type push_data,
   output logic                   pop_valid,
   input  logic                   pop_ready,
   output lss_pkg::lss_entry_type pop_data
);
   import lss_pkg::*;

   lss_entry_type     entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              do_push, do_pop;

   assign push_ready = (count_ff != (QPTR_W+1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- hw/rtl/lss_back.sv -----
// ---------------------------------------------------------------------------
// lss_back: store and search engine
// Loads term and line stores from the queue and, at line end, walks the
// line for leftmost non-overlapping occurrences, feeding the result register.
// ---------------------------------------------------------------------------
module lss_back #(
   parameter int LINE_MAX = lss_pkg::LINE_MAX_DEF,
   parameter int TERM_MAX = lss_pkg::TERM_MAX_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lss_pkg::lss_cfg_type   cfg,
   input  logic                   pop_valid,
   output logic                   pop_ready,
   input  lss_pkg::lss_entry_type pop_data,
   lss_rsp_if.source              rsp_ch
);
   import lss_pkg::*;

   localparam int LINE_AW = $clog2(LINE_MAX);
   localparam int LCNT_W  = $clog2(LINE_MAX + 1);
   localparam int TERM_AW = (TERM_MAX > 1) ? $clog2(TERM_MAX) : 1;
   localparam int TCNT_W  = $clog2(TERM_MAX + 1);
   localparam int SUM_W   = ((LCNT_W > TCNT_W) ? LCNT_W : TCNT_W) + 1;
   localparam int RCNT_W  = $clog2(MAX_RESULTS + 1);
   localparam int LENT_W  = CP_W + 1;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_CHK   = 4'd1;
   localparam logic [3:0] ST_RD    = 4'd2;
   localparam logic [3:0] ST_CMP   = 4'd3;
   localparam logic [3:0] ST_LEFT  = 4'd4;
   localparam logic [3:0] ST_LCHK  = 4'd5;
   localparam logic [3:0] ST_RIGHT = 4'd6;
   localparam logic [3:0] ST_RCHK  = 4'd7;
   localparam logic [3:0] ST_ACC   = 4'd8;
   localparam logic [3:0] ST_FIN   = 4'd9;

   // line entries carry the word-character flag above the code point
   logic [LENT_W-1:0] line_mem [LINE_MAX];
   logic [CP_W-1:0]   term_mem [TERM_MAX];
   logic [LENT_W-1:0] line_rd_ff;
   logic [CP_W-1:0]   term_rd_ff;

   logic               line_we;
   logic [LINE_AW-1:0] line_wa, line_ra;
   logic               term_we;
   logic [TERM_AW-1:0] term_wa, term_ra;

   logic [3:0]            state_ff, state_in;
   logic [LCNT_W-1:0]     pos_ff, pos_in;
   logic [TCNT_W-1:0]     k_ff, k_in;
   logic [LCNT_W-1:0]     line_count_ff, line_count_in;
   logic [TCNT_W-1:0]     term_count_ff, term_count_in;
   logic                  term_restart_ff, term_restart_in;
   logic                  dropped_ff, dropped_in;
   logic [LINE_NUM_W-1:0] line_num_ff, line_num_in;
   logic [RCNT_W-1:0]     n_ff, n_in;
   logic                  pend_ff, pend_in;
   logic [COL_W-1:0]      pend_col_ff, pend_col_in;
   logic                  ok_ff, ok_in;

   logic                  rsp_valid_ff;
   logic                  found_ff, eor_ff, ovf_ff;
   logic [LINE_NUM_W-1:0] match_line_ff;
   logic [COL_W-1:0]      col_ff;
   logic [LEN_W-1:0]      len_ff;

   logic                  out_load, out_free;
   logic                  found_in, eor_in;
   logic [COL_W-1:0]      col_in;
   logic [LEN_W-1:0]      len_in;

   logic [SUM_W-1:0]  pos_ext, lc_ext, right_sum, rk_sum, left_sum;
   logic [TCNT_W-1:0] t_eff;
   logic              last_k, char_eq;

   assign pos_ext   = SUM_W'(pos_ff);
   assign lc_ext    = SUM_W'(line_count_ff);
   assign right_sum = pos_ext + SUM_W'(term_count_ff);
   assign rk_sum    = pos_ext + SUM_W'(k_ff);
   assign left_sum  = pos_ext - 1'b1;
   assign last_k    = (TCNT_W'(k_ff + 1'b1) == term_count_ff);
   assign char_eq   = (fold_cp(line_rd_ff[CP_W-1:0], cfg.fold_case) ==
                       fold_cp(term_rd_ff, cfg.fold_case));
   assign t_eff     = term_restart_ff ? '0 : term_count_ff;
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign term_ra   = k_ff[TERM_AW-1:0];

   always_comb begin
      case (state_ff)
         ST_LEFT:  line_ra = left_sum[LINE_AW-1:0];
         ST_RIGHT: line_ra = right_sum[LINE_AW-1:0];
         default:  line_ra = rk_sum[LINE_AW-1:0];
      endcase
   end

   always_comb begin
      state_in        = state_ff;
      pos_in          = pos_ff;
      k_in            = k_ff;
      line_count_in   = line_count_ff;
      term_count_in   = term_count_ff;
      term_restart_in = term_restart_ff;
      dropped_in      = dropped_ff;
      line_num_in     = line_num_ff;
      n_in            = n_ff;
      pend_in         = pend_ff;
      pend_col_in     = pend_col_ff;
      ok_in           = ok_ff;
      pop_ready       = 1'b0;
      line_we         = 1'b0;
      line_wa         = line_count_ff[LINE_AW-1:0];
      term_we         = 1'b0;
      term_wa         = t_eff[TERM_AW-1:0];
      out_load        = 1'b0;
      found_in        = 1'b1;
      col_in          = pend_col_ff;
      len_in          = LEN_W'(term_count_ff);
      eor_in          = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               if (pop_data.kind inside {KIND_TERM, KIND_TERM_LAST}) begin
                  if (t_eff < TCNT_W'(TERM_MAX)) begin
                     term_we       = 1'b1;
                     term_count_in = t_eff + 1'b1;
                  end else begin
                     term_count_in = t_eff;
                     dropped_in    = 1'b1;
                  end
                  term_restart_in = (pop_data.kind == KIND_TERM_LAST);
               end else begin
                  if (line_count_ff < LCNT_W'(LINE_MAX)) begin
                     line_we       = 1'b1;
                     line_count_in = line_count_ff + 1'b1;
                  end else begin
                     dropped_in = 1'b1;
                  end
                  if (pop_data.kind == KIND_LINE_LAST) begin
                     line_num_in = pop_data.line_number;
                     n_in        = '0;
                     pend_in     = 1'b0;
                     pos_in      = '0;
                     k_in        = '0;
                     state_in    = ST_CHK;
                  end
               end
            end
         end
         ST_CHK: begin
            if ((term_count_ff != '0) && (n_ff < RCNT_W'(MAX_RESULTS)) &&
                (right_sum <= lc_ext)) begin
               state_in = ST_RD;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_RD: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (!char_eq) begin
               pos_in   = pos_ff + 1'b1;
               k_in     = '0;
               state_in = ST_CHK;
            end else if (last_k) begin
               ok_in    = 1'b1;
               state_in = ST_LEFT;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = ST_RD;
            end
         end
         ST_LEFT: begin
            if (!cfg.whole_word) begin
               state_in = ST_ACC;
            end else if (pos_ff != '0) begin
               state_in = ST_LCHK;
            end else begin
               state_in = ST_RIGHT;
            end
         end
         ST_LCHK: begin
            if (line_rd_ff[CP_W]) begin
               ok_in = 1'b0;
            end
            state_in = ST_RIGHT;
         end
         ST_RIGHT: begin
            if (cfg.whole_word && (right_sum < lc_ext)) begin
               state_in = ST_RCHK;
            end else begin
               state_in = ST_ACC;
            end
         end
         ST_RCHK: begin
            if (line_rd_ff[CP_W]) begin
               ok_in = 1'b0;
            end
            state_in = ST_ACC;
         end
         ST_ACC: begin
            // hold a new match while the previous match waits for the result register
            if (!(ok_ff && pend_ff && !out_free)) begin
               if (ok_ff && pend_ff) begin
                  out_load = 1'b1;
               end
               if (ok_ff) begin
                  pend_in     = 1'b1;
                  pend_col_in = COL_W'(pos_ff);
                  n_in        = n_ff + 1'b1;
               end
               pos_in   = LCNT_W'(right_sum);
               k_in     = '0;
               state_in = ST_CHK;
            end
         end
         ST_FIN: begin
            found_in = pend_ff;
            col_in   = pend_ff ? pend_col_ff : '0;
            len_in   = pend_ff ? LEN_W'(term_count_ff) : '0;
            eor_in   = 1'b1;
            if (out_free) begin
               out_load      = 1'b1;
               line_count_in = '0;
               dropped_in    = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (line_we) begin
         line_mem[line_wa] <= {pop_data.word, pop_data.cp};
      end
      line_rd_ff <= line_mem[line_ra];
   end

   always_ff @(posedge clock) begin
      if (term_we) begin
         term_mem[term_wa] <= pop_data.cp;
      end
      term_rd_ff <= term_mem[term_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         pos_ff          <= '0;
         k_ff            <= '0;
         line_count_ff   <= '0;
         term_count_ff   <= '0;
         term_restart_ff <= 1'b1;
         dropped_ff      <= 1'b0;
         n_ff            <= '0;
         pend_ff         <= 1'b0;
         ok_ff           <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         pos_ff          <= pos_in;
         k_ff            <= k_in;
         line_count_ff   <= line_count_in;
         term_count_ff   <= term_count_in;
         term_restart_ff <= term_restart_in;
         dropped_ff      <= dropped_in;
         n_ff            <= n_in;
         pend_ff         <= pend_in;
         ok_ff           <= ok_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      line_num_ff <= line_num_in;
      pend_col_ff <= pend_col_in;
      if (out_load) begin
         found_ff      <= found_in;
         match_line_ff <= line_num_ff;
         col_ff        <= col_in;
         len_ff        <= len_in;
         eor_ff        <= eor_in;
         ovf_ff        <= dropped_ff;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.found          = found_ff;
   assign rsp_ch.match_line     = match_line_ff;
   assign rsp_ch.column         = col_ff;
   assign rsp_ch.match_length   = len_ff;
   assign rsp_ch.end_of_results = eor_ff;
   assign rsp_ch.overflow       = ovf_ff;

   a_notfound_is_final: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !found_ff) |-> eor_ff)
      else $error("not-found result without end_of_results");

   a_final_clears_line: assert property (@(posedge clock) disable iff (reset)
      (out_load && eor_in) |=> (state_ff == ST_IDLE) && (line_count_ff == '0))
      else $error("line state not cleared after final result");

   a_read_in_line: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RD) |-> (right_sum <= lc_ext))
      else $error("candidate reaches past the stored line");

   a_pending_counted: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> ((n_ff != '0) && (n_ff <= RCNT_W'(MAX_RESULTS))))
      else $error("pending match not reflected in result count");

endmodule
